// File: sv/ovl_pkg.sv
// Shared codes and the float equality function for the ordered value list.
package ovl_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 7;

  localparam logic [OpW-1:0] OP_APPEND       = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE_LAST  = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE_VALUE = 2'd2;

  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  localparam logic [ValueW-2:0] InfMag = 31'h7F80_0000;

  // IEEE equality: +0 equals -0, a NaN equals nothing.
  function automatic logic fp_equal(input logic [ValueW-1:0] a, input logic [ValueW-1:0] b);
    logic nan_a;
    logic nan_b;
    logic zero_both;
    nan_a     = (a[ValueW-2:0] > InfMag);
    nan_b     = (b[ValueW-2:0] > InfMag);
    zero_both = (a[ValueW-2:0] == '0) && (b[ValueW-2:0] == '0);
    return !nan_a && !nan_b && ((a == b) || zero_both);
  endfunction

endpackage

// File: sv/ovl_store.sv
// Entry memory: one write port, one read port with registered read data.
module ovl_store
  import ovl_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ordered_value_list.sv
// Top level of the ordered value list: control, count and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | op_i, value_i
//  out     | output    | out_valid_o/out_ready_i | status_o, entry_count_o, is_empty_o
//
// Append, remove-last and the unused op code finish in the accept cycle; the
// result word shows in the cycle after. Remove-value on a non-empty list
// streams the entries through the single read port of the entry memory, one
// per cycle, and writes each entry behind a match one place lower. Reset
// clears the control state, count and flags but not the memory; entries are
// never read before they are written, so the memory needs no clearing pass.
// The result register holds a stalled word; a new word is taken in the cycle
// the pending result leaves.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [ValueW-1:0]  value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [CountW-1:0]  entry_count_o,
  output logic               is_empty_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;   // next entry to read
  logic [CW-1:0]       pidx_q, pidx_d;       // entry whose data is on rdata
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  logic [ValueW-1:0]   key_q, key_d;
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q, status_d;

  logic                accept;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [ValueW-1:0]   mem_wdata, mem_rdata;
  logic [CW+CountW-1:0] cnt_ext;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  ovl_store #(
    .Depth (LIST_DEPTH),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    pidx_d      = pidx_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = value_i;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          case (op_i)
            OP_APPEND: begin
              if (cnt_q >= DepthC) begin
                status_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + OneC;
              end
            end
            OP_REMOVE_LAST: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - OneC;
              end
            end
            OP_REMOVE_VALUE: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // hold the result until the scan ends
                out_valid_d = 1'b0;
                key_d       = value_i;
                rd_idx_d    = '0;
                found_d     = 1'b0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read while entries remain
        if (rd_idx_q < cnt_q) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + OneC;
          pend_d   = 1'b1;
          pidx_d   = rd_idx_q;
        end
        if (pend_q) begin
          if (found_q) begin
            // close the gap: move this entry one place toward the front
            mem_we    = 1'b1;
            mem_waddr = AW'(pidx_q - OneC);
            mem_wdata = mem_rdata;
          end else if (fp_equal(mem_rdata, key_q)) begin
            found_d = 1'b1;
          end
          if (pidx_q == cnt_q - OneC) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
            pend_d      = 1'b0;
            if (found_q || fp_equal(mem_rdata, key_q)) begin
              status_d = ST_DONE;
              cnt_d    = cnt_q - OneC;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    key_q    <= key_d;
    status_q <= status_d;
  end

  // count is reported modulo the width of the result field
  assign cnt_ext       = {{CountW{1'b0}}, cnt_q};
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_ext[CountW-1:0];
  assign is_empty_o    = (cnt_q == '0);

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count above list depth");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("shift write hits the entry being read");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q && found_q) |-> (pidx_q != '0))
    else $error("gap close below the first entry");

  a_remove_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_REMOVE_LAST && cnt_q != '0)
      |=> (out_valid_o && cnt_q == $past(cnt_q) - OneC))
    else $error("remove-last did not drop one entry");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ordered value list: scoreboard class, drivers, phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ovl_pkg::*;

  localparam int unsigned ListDepth = 64;
  // The op field has room for one code that the list does not use.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic               empty;
  } list_result_t;

  // Shadow of the list contents plus the queue of result words still owed.
  class list_scoreboard;
    logic [ValueW-1:0] entries [ListDepth];
    int unsigned       held;
    list_result_t      expected_q [$];
    int unsigned       errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    static function bit is_nan_word(logic [ValueW-1:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != '0);
    endfunction

    // Float equality on raw words: signed zeros match, NaN never does.
    static function bit same_float(logic [ValueW-1:0] a, logic [ValueW-1:0] b);
      if (is_nan_word(a) || is_nan_word(b)) return 1'b0;
      if ((a[30:0] == '0) && (b[30:0] == '0)) return 1'b1;
      return a == b;
    endfunction

    // Apply one accepted word to the shadow list and queue the result it owes.
    function void note_request(logic [OpW-1:0] op, logic [ValueW-1:0] value);
      list_result_t r;
      int           hit;
      r.status = ST_DONE;
      case (op)
        OP_APPEND: begin
          if (held >= ListDepth) begin
            r.status = ST_FULL;
          end else begin
            entries[held] = value;
            held++;
          end
        end
        OP_REMOVE_LAST: begin
          if (held == 0) r.status = ST_EMPTY;
          else held--;
        end
        OP_REMOVE_VALUE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            hit = -1;
            for (int i = 0; i < int'(held); i++) begin
              if (hit < 0 && same_float(entries[i], value)) hit = i;
            end
            if (hit < 0) begin
              r.status = ST_NOT_FOUND;
            end else begin
              // Close the gap: every later entry moves one place forward.
              for (int i = hit; i + 1 < int'(held); i++) entries[i] = entries[i+1];
              held--;
            end
          end
        end
        default: ;
      endcase
      r.count = CountW'(held);
      r.empty = (held == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: status %0d count %0d empty %0d",
                 $time, got.status, got.count, got.empty);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count != want.count) begin
        $display("%0t: entry_count expected %0d, got %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.empty != want.empty) begin
        $display("%0t: is_empty expected %0d, got %0d", $time, want.empty, got.empty);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     op_i          = OP_APPEND;
  logic [ValueW-1:0]  value_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;
  logic               is_empty_o;

  list_scoreboard sb;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  // Random walk direction: grow toward full, or shrink toward empty.
  bit             filling        = 1'b1;

  ordered_value_list #(
    .LIST_DEPTH(ListDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result word taken at this edge against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(list_result_t'{status_o, entry_count_o, is_empty_o});
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Edge patterns: signed zeros, infinities, quiet and signaling NaNs, extremes.
  function automatic logic [ValueW-1:0] corner_float();
    case ($urandom_range(10))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return 32'hFF80_0000;
      4:       return 32'h7FC0_0000;
      5:       return 32'h7F80_0001;
      6:       return 32'hFFFF_FFFF;
      7:       return 32'h3F80_0000;
      8:       return 32'hBF80_0000;
      9:       return 32'h0000_0001;
      default: return 32'h7F7F_FFFF;
    endcase
  endfunction

  function automatic logic [ValueW-1:0] fresh_value();
    if ($urandom_range(99) < 35) return corner_float();
    return $urandom;
  endfunction

  // Search keys: mostly something held right now, so deletions actually hit.
  function automatic logic [ValueW-1:0] search_value();
    logic [ValueW-1:0] w;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (sb.held > 0 && roll < 60) begin
      w = sb.entries[$urandom_range(sb.held - 1)];
      // Flip the sign of a zero half the time: it must still match.
      if (w[30:0] == '0 && $urandom_range(1) == 1) w[31] = ~w[31];
      return w;
    end
    if (roll < 75) return corner_float();
    return $urandom;
  endfunction

  // Present one word, hold it until accepted, then log it with the scoreboard.
  task automatic send_word(input logic [OpW-1:0] op, input logic [ValueW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, value);
  endtask

  // Drop valid and hold off until every owed result word has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_words);
    logic [OpW-1:0] op;
    int unsigned    roll;
    for (int unsigned k = 0; k < n_words; k++) begin
      // Turn around after a few tries at the full or empty boundary.
      if (filling && sb.held == ListDepth && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && sb.held == 0 && $urandom_range(2) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < 2)     op = OpUnused;
      else if (filling) op = (roll < 80) ? OP_APPEND :
                             (roll < 92) ? OP_REMOVE_VALUE : OP_REMOVE_LAST;
      else              op = (roll < 20) ? OP_APPEND :
                             (roll < 65) ? OP_REMOVE_VALUE : OP_REMOVE_LAST;
      send_word(op, (op == OP_REMOVE_VALUE) ? search_value() : fresh_value());
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Removals and the unused code on an empty list.
    send_word(OP_REMOVE_LAST, 32'hFFFF_FFFF);
    send_word(OP_REMOVE_VALUE, 32'h0000_0000);
    send_word(OpUnused, 32'h0000_0000);
    // Build a list of odd floats: +0, -0, NaN, all ones, +inf.
    send_word(OP_APPEND, 32'h0000_0000);
    send_word(OP_APPEND, 32'h8000_0000);
    send_word(OP_APPEND, 32'h7FC0_0000);
    send_word(OP_APPEND, 32'hFFFF_FFFF);
    send_word(OP_APPEND, 32'h7F80_0000);
    // NaN key matches nothing, not even a stored NaN.
    send_word(OP_REMOVE_VALUE, 32'h7FC0_0000);
    // -0 key hits the +0 at the head, leaving the -0 in place.
    send_word(OP_REMOVE_VALUE, 32'h8000_0000);
    send_word(OP_REMOVE_VALUE, 32'h1234_5678);
    send_word(OP_REMOVE_VALUE, 32'h7F80_0000);
    send_word(OpUnused, 32'hFFFF_FFFF);
    // +0 key now hits the remaining -0.
    send_word(OP_REMOVE_VALUE, 32'h0000_0000);
    send_word(OP_REMOVE_LAST, 32'h0000_0000);
    send_word(OP_REMOVE_LAST, 32'h0000_0000);
    send_word(OP_REMOVE_LAST, 32'h0000_0000);
    send_word(OP_REMOVE_VALUE, 32'hFFFF_FFFF);
    wait_drained();

    // Idle phases: none, sender only, receiver only, both.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 53 : (p == 3) ? 34 : 0;
      recv_stall_pct = (p == 2) ? 53 : (p == 3) ? 34 : 0;
      run_random(258);
      wait_drained();
    end

    // Let any stray late word show up before the verdict.
    repeat (ListDepth + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
